// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the power button stretch block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PBS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PBS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/pbs_pkg.sv =====
// ----------------------------------------------------------------------------
// pbs_pkg
// Types, codes and constants of the power button stretch state machine.
// ----------------------------------------------------------------------------
package pbs_pkg;

   localparam int TIME_BITS_DEF = 32;
   localparam logic [15:0] RETRY_TICKS = 16'd100;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 3;

   // register indexes
   localparam logic [REG_IDX_BITS-1:0] REG_PULSE_ENABLE  = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_FIRST_PULSE   = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_GAP           = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_WAKE_PULSE    = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_FIRST_HOLD    = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_SECOND_HOLD   = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_INIT_TIMEOUT  = 3'd6;
   localparam logic [REG_IDX_BITS-1:0] REG_START_ON      = 3'd7;

   // force command codes
   localparam logic [1:0] FORCE_NONE    = 2'd0;
   localparam logic [1:0] FORCE_PRESS   = 2'd1;
   localparam logic [1:0] FORCE_RELEASE = 2'd2;

   // shutdown cause codes
   localparam logic [1:0] CAUSE_NONE   = 2'd0;
   localparam logic [1:0] CAUSE_FIRST  = 2'd1;
   localparam logic [1:0] CAUSE_SECOND = 2'd2;

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_PRESSED  = 12'b0000_0000_0010,
      ST_T1       = 12'b0000_0000_0100,
      ST_HELD     = 12'b0000_0000_1000,
      ST_HELD2    = 12'b0000_0001_0000,
      ST_LID      = 12'b0000_0010_0000,
      ST_LAN      = 12'b0000_0100_0000,
      ST_RELEASED = 12'b0000_1000_0000,
      ST_EAT      = 12'b0001_0000_0000,
      ST_INIT_ON  = 12'b0010_0000_0000,
      ST_BOOT     = 12'b0100_0000_0000,
      ST_WAS_OFF  = 12'b1000_0000_0000
   } pbs_state_type;

   // which delay a freshly armed deadline was built from
   typedef enum logic [2:0] {
      DL_STORED = 3'd0,
      DL_WAKE   = 3'd1,
      DL_FIRST  = 3'd2,
      DL_GAP    = 3'd3,
      DL_HOLD1  = 3'd4,
      DL_HOLD2  = 3'd5,
      DL_RETRY  = 3'd6,
      DL_ZERO   = 3'd7
   } pbs_dl_sel_type;

   localparam int DL_COUNT = 8;

   typedef struct packed {
      pbs_state_type  state;
      logic           dl_valid;
      pbs_dl_sel_type dl_sel;
      logic           line;
      logic           exit_hard_off;
      logic [1:0]     cause;
      logic           shutdown_request;
   } pbs_pass_type;

   typedef struct packed {
      logic button;
      logic chipset_off;
      logic battery_blocks;
      logic pulse_enable;
      logic timeout_hit;
   } pbs_ctl_type;

   function automatic logic [3:0] state_code(pbs_state_type s);
      logic [3:0] code;
      unique case (s)
         ST_IDLE:     code = 4'd0;
         ST_PRESSED:  code = 4'd1;
         ST_T1:       code = 4'd2;
         ST_HELD:     code = 4'd3;
         ST_HELD2:    code = 4'd4;
         ST_LID:      code = 4'd5;
         ST_LAN:      code = 4'd6;
         ST_RELEASED: code = 4'd7;
         ST_EAT:      code = 4'd8;
         ST_INIT_ON:  code = 4'd9;
         ST_BOOT:     code = 4'd10;
         ST_WAS_OFF:  code = 4'd11;
         default:     code = 4'd0;
      endcase
      return code;
   endfunction

endpackage

// ===== src/pbs_pass.sv =====
// ----------------------------------------------------------------------------
// pbs_pass
// One evaluation of the button state machine on an expired or fresh deadline.
// ----------------------------------------------------------------------------
module pbs_pass (
   input  logic                  run,
   input  pbs_pkg::pbs_ctl_type  ctl,
   input  pbs_pkg::pbs_pass_type ps_in,
   output pbs_pkg::pbs_pass_type ps_out
);
   import pbs_pkg::*;

   logic line_low;

   // asserting the line is overridden while the battery holds the chipset off
   assign line_low = ctl.chipset_off & ctl.battery_blocks;

   always_comb begin
      ps_out = ps_in;
      if (run) begin
         ps_out.dl_valid = 1'b0;
         unique case (ps_in.state) inside
            ST_PRESSED: begin
               ps_out.dl_valid = 1'b1;
               ps_out.state    = ST_T1;
               if (ctl.chipset_off) begin
                  ps_out.exit_hard_off = 1'b1;
                  ps_out.dl_sel        = DL_WAKE;
                  ps_out.state         = ST_WAS_OFF;
                  ps_out.line          = line_low;
               end else if (ctl.pulse_enable) begin
                  ps_out.dl_sel = DL_FIRST;
                  ps_out.line   = line_low;
               end else begin
                  ps_out.dl_sel = DL_GAP;
               end
            end
            ST_T1: begin
               if (!ctl.chipset_off) begin
                  ps_out.line = line_low;
               end
               ps_out.dl_valid = 1'b1;
               ps_out.dl_sel   = DL_HOLD1;
               ps_out.state    = ST_HELD;
            end
            ST_RELEASED, ST_LID, ST_LAN: begin
               ps_out.line  = 1'b1;
               ps_out.state = ST_IDLE;
            end
            ST_INIT_ON: begin
               if (ctl.battery_blocks) begin
                  if (ctl.timeout_hit) begin
                     ps_out.state = ST_IDLE;
                  end else begin
                     ps_out.dl_valid = 1'b1;
                     ps_out.dl_sel   = DL_RETRY;
                  end
               end else begin
                  ps_out.exit_hard_off = 1'b1;
                  ps_out.line          = line_low;
                  ps_out.dl_valid      = 1'b1;
                  ps_out.dl_sel        = DL_WAKE;
                  ps_out.state         = ST_BOOT;
               end
            end
            ST_BOOT: begin
               ps_out.line  = 1'b1;
               ps_out.state = ctl.button ? ST_EAT : ST_IDLE;
            end
            ST_WAS_OFF: begin
               if (ctl.button) begin
                  ps_out.state = ST_HELD;
               end else begin
                  ps_out.state    = ST_RELEASED;
                  ps_out.dl_valid = 1'b1;
                  ps_out.dl_sel   = DL_ZERO;
               end
            end
            ST_HELD: begin
               ps_out.cause    = CAUSE_FIRST;
               ps_out.dl_valid = 1'b1;
               ps_out.dl_sel   = DL_HOLD2;
               ps_out.state    = ST_HELD2;
            end
            ST_HELD2: begin
               ps_out.cause            = CAUSE_SECOND;
               ps_out.shutdown_request = 1'b1;
            end
            ST_IDLE, ST_EAT: begin
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== src/power_button_stretch_fsm_core.sv =====
// ----------------------------------------------------------------------------
// power_button_stretch_fsm_core
// Power button stretch controller: one millisecond tick per request beat.
// ----------------------------------------------------------------------------
// Each request beat is one tick. A beat is taken every cycle unless the
// result register is full and stalled; its result beat appears in the next
// cycle. Edge detection, the wake pulses and up to four chained machine
// passes (pbs_pass) are evaluated in the same cycle, with all candidate
// deadlines added to the tick counter in parallel, so the rate is one tick
// per clock while the result side does not stall. Registers sit on an APB
// port at byte address 4*i; the start_on register also sets the state until
// the first tick is taken.
module power_button_stretch_fsm_core #(
   parameter int TIME_BITS = pbs_pkg::TIME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_button_pressed,
   input  logic                               req_chipset_off,
   input  logic                               req_chipset_sleeping,
   input  logic                               req_lid_open,
   input  logic                               req_lan_wake,
   input  logic                               req_battery_blocks,
   input  logic [1:0]                         req_force_command,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_pch_button_level,
   output logic                               rsp_exit_hard_off,
   output logic [1:0]                         rsp_shutdown_cause,
   output logic                               rsp_shutdown_request,
   output logic [3:0]                         rsp_machine_code,
   // configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pbs_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [pbs_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [pbs_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import pbs_pkg::*;
`include "assert_macros.svh"

   localparam int PASSES = 4;

   // configuration
   logic        pulse_enable_ff;
   logic [15:0] first_pulse_ff;
   logic [15:0] gap_ff;
   logic [15:0] wake_pulse_ff;
   logic [15:0] first_hold_ff;
   logic [15:0] second_hold_ff;
   logic [15:0] init_timeout_ff;
   logic        start_on_ff;

   // machine state
   pbs_state_type        state_ff, state_in;
   logic [TIME_BITS-1:0] deadline_ff, deadline_in;
   logic                 dl_valid_ff;
   logic [TIME_BITS-1:0] time_ff;
   logic                 prev_button_ff, prev_lid_ff, prev_lan_ff;
   logic                 line_ff;
   logic                 started_ff;

   // result register
   logic          rsp_valid_ff;
   logic          rsp_line_ff;
   logic          rsp_exit_ff;
   logic [1:0]    rsp_cause_ff;
   logic          rsp_req_ff;
   pbs_state_type rsp_state_ff;

   logic                  in_accept;
   logic                  csr_write;
   logic [REG_IDX_BITS-1:0] csr_idx;
   logic                  line_low;
   logic [15:0]           dly [DL_COUNT];
   logic [TIME_BITS:0]    sum_ext [DL_COUNT];
   logic [DL_COUNT-1:0]   due;
   logic                  woken;
   logic                  run [PASSES];
   pbs_ctl_type           ctl;
   pbs_pass_type          pre;
   pbs_pass_type          ps [PASSES+1];
   pbs_pass_type          fin;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign in_accept  = req_valid & ~req_stall;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   // level an asserted line takes: held released while the battery gates it
   assign line_low   = req_chipset_off & req_battery_blocks;

   always_comb begin
      unique case (csr_idx)
         REG_PULSE_ENABLE: csr_prdata = CSR_DATA_BITS'(pulse_enable_ff);
         REG_FIRST_PULSE:  csr_prdata = CSR_DATA_BITS'(first_pulse_ff);
         REG_GAP:          csr_prdata = CSR_DATA_BITS'(gap_ff);
         REG_WAKE_PULSE:   csr_prdata = CSR_DATA_BITS'(wake_pulse_ff);
         REG_FIRST_HOLD:   csr_prdata = CSR_DATA_BITS'(first_hold_ff);
         REG_SECOND_HOLD:  csr_prdata = CSR_DATA_BITS'(second_hold_ff);
         REG_INIT_TIMEOUT: csr_prdata = CSR_DATA_BITS'(init_timeout_ff);
         REG_START_ON:     csr_prdata = CSR_DATA_BITS'(start_on_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // every candidate deadline; a wrapped or zero-length one is due at once
   always_comb begin
      dly[DL_STORED] = 16'd0;
      dly[DL_WAKE]   = wake_pulse_ff;
      dly[DL_FIRST]  = first_pulse_ff;
      dly[DL_GAP]    = gap_ff;
      dly[DL_HOLD1]  = first_hold_ff;
      dly[DL_HOLD2]  = second_hold_ff;
      dly[DL_RETRY]  = RETRY_TICKS;
      dly[DL_ZERO]   = 16'd0;
      for (int i = 0; i < DL_COUNT; i++) begin
         sum_ext[i] = {1'b0, time_ff} + (TIME_BITS+1)'(dly[i]);
         due[i]     = sum_ext[i][TIME_BITS] | (dly[i] == 16'd0);
      end
      due[DL_STORED] = (time_ff >= deadline_ff);
   end

   assign ctl.button         = req_button_pressed;
   assign ctl.chipset_off    = req_chipset_off;
   assign ctl.battery_blocks = req_battery_blocks;
   assign ctl.pulse_enable   = pulse_enable_ff;
   assign ctl.timeout_hit    = (TIME_BITS+16)'(time_ff) > (TIME_BITS+16)'(init_timeout_ff);

   // force command, button edge, lid and LAN wake ahead of the machine
   always_comb begin
      pre.state            = state_ff;
      pre.dl_valid         = dl_valid_ff;
      pre.dl_sel           = DL_STORED;
      pre.line             = line_ff;
      pre.exit_hard_off    = 1'b0;
      pre.cause            = CAUSE_NONE;
      pre.shutdown_request = 1'b0;
      woken                = ~started_ff;

      case (req_force_command)
         FORCE_PRESS: begin
            if (!req_button_pressed) begin
               pre.line = line_low;
            end
         end
         FORCE_RELEASE: begin
            pre.line  = 1'b1;
            pre.state = req_button_pressed ? ST_EAT : ST_IDLE;
         end
         default: begin
         end
      endcase

      if (req_button_pressed != prev_button_ff) begin
         if (!(pre.state == ST_BOOT || pre.state == ST_INIT_ON || pre.state == ST_LID ||
               pre.state == ST_LAN || pre.state == ST_WAS_OFF)) begin
            if (req_button_pressed) begin
               pre.state    = ST_PRESSED;
               pre.dl_valid = 1'b0;
               woken        = 1'b1;
            end else if (pre.state == ST_EAT) begin
               pre.state = ST_IDLE;
            end else begin
               pre.state    = ST_RELEASED;
               pre.dl_valid = 1'b0;
               woken        = 1'b1;
            end
         end
      end

      if (req_lid_open && !prev_lid_ff && req_chipset_off && pre.state != ST_INIT_ON) begin
         pre.exit_hard_off = 1'b1;
         pre.line          = line_low;
         pre.state         = ST_LID;
         pre.dl_valid      = 1'b1;
         pre.dl_sel        = DL_WAKE;
         woken             = 1'b1;
      end

      if (req_lan_wake && !prev_lan_ff && req_chipset_sleeping && pre.state != ST_INIT_ON) begin
         pre.exit_hard_off = 1'b1;
         pre.line          = line_low;
         pre.state         = ST_LAN;
         pre.dl_valid      = 1'b1;
         pre.dl_sel        = DL_WAKE;
         woken             = 1'b1;
      end
   end

   // first pass runs on a wake with no pending deadline or on an expired one;
   // later passes only while the deadline just armed is already due
   assign ps[0] = pre;

   genvar gp;
   generate
      for (gp = 0; gp < PASSES; gp++) begin : g_pass
         if (gp == 0) begin : g_first
            assign run[gp] = ps[gp].dl_valid ? due[ps[gp].dl_sel] : woken;
         end else begin : g_next
            assign run[gp] = ps[gp].dl_valid & due[ps[gp].dl_sel];
         end
         pbs_pass u_pass (
            .run    (run[gp]),
            .ctl    (ctl),
            .ps_in  (ps[gp]),
            .ps_out (ps[gp+1])
         );
      end
   endgenerate

   assign fin      = ps[PASSES];
   assign state_in = fin.state;

   always_comb begin
      if (fin.dl_sel == DL_STORED) begin
         deadline_in = deadline_ff;
      end else begin
         deadline_in = sum_ext[fin.dl_sel][TIME_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_enable_ff <= 1'b1;
         first_pulse_ff  <= 16'd32;
         gap_ff          <= 16'd32;
         wake_pulse_ff   <= 16'd200;
         first_hold_ff   <= 16'd3700;
         second_hold_ff  <= 16'd6300;
         init_timeout_ff <= 16'd1000;
         start_on_ff     <= 1'b1;
         state_ff        <= ST_INIT_ON;
         deadline_ff     <= '0;
         dl_valid_ff     <= 1'b0;
         time_ff         <= '0;
         prev_button_ff  <= 1'b0;
         prev_lid_ff     <= 1'b0;
         prev_lan_ff     <= 1'b0;
         line_ff         <= 1'b1;
         started_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_idx)
               REG_PULSE_ENABLE: pulse_enable_ff <= csr_pwdata[0];
               REG_FIRST_PULSE:  first_pulse_ff  <= csr_pwdata[15:0];
               REG_GAP:          gap_ff          <= csr_pwdata[15:0];
               REG_WAKE_PULSE:   wake_pulse_ff   <= csr_pwdata[15:0];
               REG_FIRST_HOLD:   first_hold_ff   <= csr_pwdata[15:0];
               REG_SECOND_HOLD:  second_hold_ff  <= csr_pwdata[15:0];
               REG_INIT_TIMEOUT: init_timeout_ff <= csr_pwdata[15:0];
               REG_START_ON:     start_on_ff     <= csr_pwdata[0];
               default: begin
               end
            endcase
         end

         if (in_accept) begin
            state_ff       <= state_in;
            deadline_ff    <= deadline_in;
            dl_valid_ff    <= fin.dl_valid;
            time_ff        <= time_ff + TIME_BITS'(1);
            prev_button_ff <= req_button_pressed;
            prev_lid_ff    <= req_lid_open;
            prev_lan_ff    <= req_lan_wake;
            line_ff        <= fin.line;
            started_ff     <= 1'b1;
         end else if (csr_write && csr_idx == REG_START_ON && !started_ff) begin
            state_ff <= csr_pwdata[0] ? ST_INIT_ON : ST_IDLE;
         end

         if (in_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         rsp_line_ff  <= fin.line;
         rsp_exit_ff  <= fin.exit_hard_off;
         rsp_cause_ff <= fin.cause;
         rsp_req_ff   <= fin.shutdown_request;
         rsp_state_ff <= fin.state;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pch_button_level = rsp_line_ff;
   assign rsp_exit_hard_off    = rsp_exit_ff;
   assign rsp_shutdown_cause   = rsp_cause_ff;
   assign rsp_shutdown_request = rsp_req_ff;
   assign rsp_machine_code     = state_code(rsp_state_ff);

   `PBS_ASSERT_NXT(a_tick_advances, clock, reset, in_accept, time_ff == TIME_BITS'($past(time_ff) + TIME_BITS'(1)), "tick counter did not advance on an accepted beat")
   `PBS_ASSERT_NXT(a_result_follows, clock, reset, in_accept, rsp_valid_ff, "accepted beat left no result")
   `PBS_ASSERT_NXT(a_started_sticks, clock, reset, started_ff, started_ff, "started flag dropped")
   `PBS_ASSERT_IMP(a_shutdown_cause, clock, reset, rsp_valid_ff && rsp_req_ff, rsp_cause_ff == CAUSE_SECOND, "shutdown request without second stage cause")

endmodule

// ===== tb/pbs_line_checker.sv =====
// ----------------------------------------------------------------------------
// pbs_line_checker
// Watches the tick and result channels of the power button stretch block,
// tracks register writes, forecasts each tick's line/pulse/state outputs and
// compares every result beat against the oldest forecast.
// ----------------------------------------------------------------------------
module pbs_line_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               req_button_pressed,
   input  logic                               req_chipset_off,
   input  logic                               req_chipset_sleeping,
   input  logic                               req_lid_open,
   input  logic                               req_lan_wake,
   input  logic                               req_battery_blocks,
   input  logic [1:0]                         req_force_command,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic                               rsp_pch_button_level,
   input  logic                               rsp_exit_hard_off,
   input  logic [1:0]                         rsp_shutdown_cause,
   input  logic                               rsp_shutdown_request,
   input  logic [3:0]                         rsp_machine_code,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pbs_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [pbs_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input  logic                               csr_pready,
   output int                                 failures,
   output int                                 outstanding,
   output int                                 ticks_checked,
   output int                                 shutdowns_seen,
   output logic [11:0]                        codes_seen
);
   import pbs_pkg::*;

   localparam logic [31:0] RETRY_WAIT = 32'd100;

   typedef enum logic [3:0] {
      M_IDLE     = 4'd0,
      M_PRESSED  = 4'd1,
      M_PRE_HOLD = 4'd2,
      M_HELD     = 4'd3,
      M_HELD2    = 4'd4,
      M_LID      = 4'd5,
      M_LAN      = 4'd6,
      M_RELEASED = 4'd7,
      M_EAT      = 4'd8,
      M_INIT_ON  = 4'd9,
      M_BOOT     = 4'd10,
      M_WAS_OFF  = 4'd11
   } mode_type;

   typedef struct packed {
      logic       level;
      logic       exit_hard_off;
      logic [1:0] cause;
      logic       shutdown;
      mode_type   mode;
   } tick_out_type;

   // timing registers
   logic        cfg_pulse_en;
   logic [15:0] cfg_first_pulse, cfg_gap, cfg_wake, cfg_hold1, cfg_hold2;
   logic [15:0] cfg_init_timeout;
   logic        cfg_start_on;

   // machine copy
   mode_type    mode;
   logic [31:0] deadline;
   logic        deadline_armed;
   logic [31:0] now_tick;
   logic        last_btn, last_lid, last_lan;
   logic        pch_line;
   logic        ticked;

   // levels and pulses of the tick being evaluated
   logic        cur_btn, cur_off, cur_batt;
   logic        pulse_exit, pulse_req;
   logic [1:0]  cur_cause;

   tick_out_type line_forecast[$];
   tick_out_type oldest;

   function automatic void reset_model();
      cfg_pulse_en     = 1'b1;
      cfg_first_pulse  = 16'd32;
      cfg_gap          = 16'd32;
      cfg_wake         = 16'd200;
      cfg_hold1        = 16'd3700;
      cfg_hold2        = 16'd6300;
      cfg_init_timeout = 16'd1000;
      cfg_start_on     = 1'b1;
      mode             = M_INIT_ON;
      deadline         = '0;
      deadline_armed   = 1'b0;
      now_tick         = '0;
      last_btn         = 1'b0;
      last_lid         = 1'b0;
      last_lan         = 1'b0;
      pch_line         = 1'b1;
      ticked           = 1'b0;
   endfunction

   function automatic void write_register(input logic [CSR_ADDR_BITS-1:0] addr,
                                          input logic [CSR_DATA_BITS-1:0] data);
      case (addr[CSR_ADDR_BITS-1:2])
         REG_PULSE_ENABLE: cfg_pulse_en     = data[0];
         REG_FIRST_PULSE:  cfg_first_pulse  = data[15:0];
         REG_GAP:          cfg_gap          = data[15:0];
         REG_WAKE_PULSE:   cfg_wake         = data[15:0];
         REG_FIRST_HOLD:   cfg_hold1        = data[15:0];
         REG_SECOND_HOLD:  cfg_hold2        = data[15:0];
         REG_INIT_TIMEOUT: cfg_init_timeout = data[15:0];
         REG_START_ON: begin
            cfg_start_on = data[0];
            // only moves the machine until the first tick has gone through
            if (!ticked)
               mode = data[0] ? M_INIT_ON : M_IDLE;
         end
         default: ;
      endcase
   endfunction

   // battery gate: never pull the line while off and the battery blocks
   function automatic void drive_pch(input logic high);
      if (!high && cur_off && cur_batt)
         high = 1'b1;
      pch_line = high;
   endfunction

   function automatic void arm_deadline(input logic [31:0] base, input logic [31:0] span);
      deadline       = base + span;
      deadline_armed = 1'b1;
   endfunction

   function automatic void wake_pulse(input mode_type target, input logic [31:0] tnow);
      pulse_exit = 1'b1;
      drive_pch(1'b0);
      mode = target;
      arm_deadline(tnow, {16'd0, cfg_wake});
   endfunction

   function automatic void machine_pass(input logic [31:0] tnow);
      if (deadline_armed && tnow < deadline)
         return;
      deadline_armed = 1'b0;
      case (mode) inside
         M_PRESSED: begin
            if (cur_off) begin
               pulse_exit = 1'b1;
               arm_deadline(tnow, {16'd0, cfg_wake});
               mode = M_WAS_OFF;
               drive_pch(1'b0);
            end else if (cfg_pulse_en) begin
               arm_deadline(tnow, {16'd0, cfg_first_pulse});
               mode = M_PRE_HOLD;
               drive_pch(1'b0);
            end else begin
               arm_deadline(tnow, {16'd0, cfg_gap});
               mode = M_PRE_HOLD;
            end
         end
         M_PRE_HOLD: begin
            if (!cur_off)
               drive_pch(1'b0);
            arm_deadline(tnow, {16'd0, cfg_hold1});
            mode = M_HELD;
         end
         M_RELEASED, M_LID, M_LAN: begin
            drive_pch(1'b1);
            mode = M_IDLE;
         end
         M_INIT_ON: begin
            if (cur_batt) begin
               if (tnow > {16'd0, cfg_init_timeout})
                  mode = M_IDLE;
               else
                  arm_deadline(tnow, RETRY_WAIT);
            end else begin
               pulse_exit = 1'b1;
               drive_pch(1'b0);
               arm_deadline(tnow, {16'd0, cfg_wake});
               mode = M_BOOT;
            end
         end
         M_BOOT: begin
            drive_pch(1'b1);
            mode = cur_btn ? M_EAT : M_IDLE;
         end
         M_WAS_OFF: begin
            if (cur_btn) begin
               mode = M_HELD;
            end else begin
               mode = M_RELEASED;
               arm_deadline(tnow, 32'd0);
            end
         end
         M_HELD: begin
            cur_cause = CAUSE_FIRST;
            arm_deadline(tnow, {16'd0, cfg_hold2});
            mode = M_HELD2;
         end
         M_HELD2: begin
            cur_cause = CAUSE_SECOND;
            pulse_req = 1'b1;
         end
         default: ;
      endcase
   endfunction

   function automatic tick_out_type step_button_machine(input logic btn, input logic off,
                                                        input logic sleeping, input logic lid,
                                                        input logic lan, input logic batt,
                                                        input logic [1:0] force_cmd);
      logic [31:0]  tnow;
      logic         woken;
      mode_type     prior;
      tick_out_type r;
      tnow       = now_tick;
      woken      = !ticked;
      cur_btn    = btn;
      cur_off    = off;
      cur_batt   = batt;
      pulse_exit = 1'b0;
      pulse_req  = 1'b0;
      cur_cause  = CAUSE_NONE;
      ticked     = 1'b1;

      if (force_cmd == FORCE_PRESS) begin
         if (!btn)
            drive_pch(1'b0);
      end else if (force_cmd == FORCE_RELEASE) begin
         drive_pch(1'b1);
         mode = btn ? M_EAT : M_IDLE;
      end

      if (btn != last_btn) begin
         prior = mode;
         if (!(prior inside {M_BOOT, M_INIT_ON, M_LID, M_LAN, M_WAS_OFF})) begin
            if (btn) begin
               mode = M_PRESSED;
               deadline_armed = 1'b0;
               woken = 1'b1;
            end else if (prior == M_EAT) begin
               mode = M_IDLE;
            end else begin
               mode = M_RELEASED;
               deadline_armed = 1'b0;
               woken = 1'b1;
            end
         end
      end

      if (lid && !last_lid && off && mode != M_INIT_ON) begin
         wake_pulse(M_LID, tnow);
         woken = 1'b1;
      end
      if (lan && !last_lan && sleeping && mode != M_INIT_ON) begin
         wake_pulse(M_LAN, tnow);
         woken = 1'b1;
      end
      last_btn = btn;
      last_lid = lid;
      last_lan = lan;

      // chained passes while a freshly armed deadline is already due
      if (woken || (deadline_armed && tnow >= deadline)) begin
         for (int p = 0; p < 4; p++) begin
            machine_pass(tnow);
            if (!(deadline_armed && deadline <= tnow))
               break;
         end
      end
      now_tick = tnow + 32'd1;

      r.level         = pch_line;
      r.exit_hard_off = pulse_exit;
      r.cause         = cur_cause;
      r.shutdown      = pulse_req;
      r.mode          = mode;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [3:0] want_v,
                                       input logic [3:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
         line_forecast.delete();
         failures       = 0;
         ticks_checked  = 0;
         shutdowns_seen = 0;
         codes_seen     = '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            write_register(csr_paddr, csr_pwdata);
         if (rsp_valid && !rsp_stall) begin
            if (line_forecast.size() == 0) begin
               $error("result beat with no tick waiting for it");
               failures++;
            end else begin
               oldest = line_forecast.pop_front();
               check_field("pch_button_level", 4'(oldest.level), 4'(rsp_pch_button_level));
               check_field("exit_hard_off", 4'(oldest.exit_hard_off), 4'(rsp_exit_hard_off));
               check_field("shutdown_cause", 4'(oldest.cause), 4'(rsp_shutdown_cause));
               check_field("shutdown_request", 4'(oldest.shutdown),
                           4'(rsp_shutdown_request));
               check_field("machine_code", oldest.mode, rsp_machine_code);
               ticks_checked++;
               if (oldest.shutdown)
                  shutdowns_seen++;
               codes_seen[oldest.mode] = 1'b1;
            end
         end
         if (req_valid && !req_stall)
            line_forecast.push_back(step_button_machine(
               req_button_pressed, req_chipset_off, req_chipset_sleeping, req_lid_open,
               req_lan_wake, req_battery_blocks, req_force_command));
      end
      outstanding = line_forecast.size();
   end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the power button stretch block with millisecond ticks: a start-up
// power-on with battery retries, a short directed set, then phases of random
// press, lid, LAN, force and noise episodes under changing timing registers,
// with random idle bursts on both channels. The checker module does the
// forecasting and comparison; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------
module testbench;
   import pbs_pkg::*;

   localparam int          PHASES       = 6;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam logic [1:0]  FORCE_UNUSED = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_button_pressed = 1'b0;
   logic                     req_chipset_off = 1'b0;
   logic                     req_chipset_sleeping = 1'b0;
   logic                     req_lid_open = 1'b0;
   logic                     req_lan_wake = 1'b0;
   logic                     req_battery_blocks = 1'b0;
   logic [1:0]               req_force_command = FORCE_NONE;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_pch_button_level;
   logic                     rsp_exit_hard_off;
   logic [1:0]               rsp_shutdown_cause;
   logic                     rsp_shutdown_request;
   logic [3:0]               rsp_machine_code;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int          failures, outstanding, ticks_checked, shutdowns_seen;
   logic [11:0] codes_seen;
   int          idle_pct = 20;
   int          ticks_sent = 0;
   int          stall_left = 0;
   int          cycles = 0;
   logic        lv_btn = 1'b0, lv_off = 1'b0, lv_sleep = 1'b0;
   logic        lv_lid = 1'b0, lv_lan = 1'b0, lv_batt = 1'b0;

   power_button_stretch_fsm_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_button_pressed   (req_button_pressed),
      .req_chipset_off      (req_chipset_off),
      .req_chipset_sleeping (req_chipset_sleeping),
      .req_lid_open         (req_lid_open),
      .req_lan_wake         (req_lan_wake),
      .req_battery_blocks   (req_battery_blocks),
      .req_force_command    (req_force_command),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pch_button_level (rsp_pch_button_level),
      .rsp_exit_hard_off    (rsp_exit_hard_off),
      .rsp_shutdown_cause   (rsp_shutdown_cause),
      .rsp_shutdown_request (rsp_shutdown_request),
      .rsp_machine_code     (rsp_machine_code),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   pbs_line_checker watch (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_button_pressed   (req_button_pressed),
      .req_chipset_off      (req_chipset_off),
      .req_chipset_sleeping (req_chipset_sleeping),
      .req_lid_open         (req_lid_open),
      .req_lan_wake         (req_lan_wake),
      .req_battery_blocks   (req_battery_blocks),
      .req_force_command    (req_force_command),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pch_button_level (rsp_pch_button_level),
      .rsp_exit_hard_off    (rsp_exit_hard_off),
      .rsp_shutdown_cause   (rsp_shutdown_cause),
      .rsp_shutdown_request (rsp_shutdown_request),
      .rsp_machine_code     (rsp_machine_code),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_pready           (csr_pready),
      .failures             (failures),
      .outstanding          (outstanding),
      .ticks_checked        (ticks_checked),
      .shutdowns_seen       (shutdowns_seen),
      .codes_seen           (codes_seen)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result-side stall in random bursts
   always @(posedge clock) begin
      if (reset || idle_pct == 0) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic coin(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic logic [1:0] pick_force();
      case ($urandom_range(0, 3))
         0:       return FORCE_NONE;
         1:       return FORCE_PRESS;
         2:       return FORCE_RELEASE;
         default: return FORCE_UNUSED;
      endcase
   endfunction

   task automatic send_tick(input logic btn, input logic off, input logic sleeping,
                            input logic lid, input logic lan, input logic batt,
                            input logic [1:0] force_cmd);
      if (idle_pct != 0 && coin(idle_pct)) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_button_pressed   <= btn;
      req_chipset_off      <= off;
      req_chipset_sleeping <= sleeping;
      req_lid_open         <= lid;
      req_lan_wake         <= lan;
      req_battery_blocks   <= batt;
      req_force_command    <= force_cmd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
   endtask

   // n ticks at the current levels, the command only on the first
   task automatic send_levels(input logic [1:0] force_cmd, input int n);
      for (int i = 0; i < n; i++)
         send_tick(lv_btn, lv_off, lv_sleep, lv_lid, lv_lan, lv_batt,
                   (i == 0) ? force_cmd : FORCE_NONE);
   endtask

   task automatic csr_write(input logic [REG_IDX_BITS-1:0] idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic load_timing(input logic pulse_en, input logic [15:0] first_pulse,
                              input logic [15:0] gap, input logic [15:0] wake,
                              input logic [15:0] hold1, input logic [15:0] hold2,
                              input logic [15:0] init_timeout, input logic start_on);
      csr_write(REG_PULSE_ENABLE, {15'd0, pulse_en});
      csr_write(REG_FIRST_PULSE, first_pulse);
      csr_write(REG_GAP, gap);
      csr_write(REG_WAKE_PULSE, wake);
      csr_write(REG_FIRST_HOLD, hold1);
      csr_write(REG_SECOND_HOLD, hold2);
      csr_write(REG_INIT_TIMEOUT, init_timeout);
      csr_write(REG_START_ON, {15'd0, start_on});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // stop sending and let every result beat drain before touching registers
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic run_episode();
      int kind;
      kind     = $urandom_range(0, 9);
      lv_off   = coin(30);
      lv_sleep = coin(30);
      lv_batt  = coin(20);
      case (kind) inside
         [0:4]: begin
            // long enough holds reach both cause stages and the shutdown
            lv_btn = 1'b1;
            send_levels(FORCE_NONE, $urandom_range(1, 60));
            lv_btn = 1'b0;
            send_levels(FORCE_NONE, $urandom_range(1, 12));
         end
         5: begin
            lv_off = coin(85);
            lv_lid = 1'b0;
            send_levels(FORCE_NONE, $urandom_range(1, 3));
            lv_lid = 1'b1;
            send_levels(FORCE_NONE, $urandom_range(1, 12));
         end
         6: begin
            lv_sleep = coin(85);
            lv_lan   = 1'b0;
            send_levels(FORCE_NONE, $urandom_range(1, 3));
            lv_lan = 1'b1;
            send_levels(FORCE_NONE, $urandom_range(1, 12));
         end
         7: begin
            lv_btn = coin(50);
            send_levels(pick_force(), 1);
            send_levels(FORCE_NONE, $urandom_range(1, 8));
         end
         default: begin
            repeat ($urandom_range(1, 10)) begin
               {lv_btn, lv_off, lv_sleep, lv_lid, lv_lan, lv_batt} = 6'($urandom);
               send_levels(pick_force(), 1);
            end
         end
      endcase
   endtask

   initial begin
      int          blocked;
      int          target;
      logic [15:0] timeout;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // start-up power-on: battery holds it back for a while, then may time out
      case ($urandom_range(0, 2))
         0:       timeout = 16'd0;
         1:       timeout = 16'd150;
         default: timeout = 16'hFFFF;
      endcase
      csr_write(REG_START_ON, 16'd0);
      load_timing(1'b1, 16'd3, 16'd0, 16'd4, 16'd6, 16'd5, timeout, 1'b1);
      @(posedge clock);
      blocked = $urandom_range(0, 300);
      for (int i = 0; i < blocked + 20; i++)
         send_tick(coin(5), 1'b1, coin(50), coin(50), coin(50), i < blocked, FORCE_NONE);

      settle();
      load_timing(1'b1, 16'd2, 16'd0, 16'd3, 16'd3, 16'd2, 16'd1000, 1'b1);
      @(posedge clock);
      // unused command acts as none
      send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORCE_UNUSED);
      // hold through to shutdown
      repeat (9) send_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORCE_NONE);
      send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORCE_NONE);
      // press while off, battery gated
      repeat (5) send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, FORCE_NONE);
      send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, FORCE_NONE);
      // lid opens while off
      send_tick(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, FORCE_NONE);
      // LAN wake while asleep
      send_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, FORCE_NONE);
      // forced release together with a fresh press; the press edge overrides it
      send_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORCE_RELEASE);
      send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORCE_NONE);
      send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORCE_PRESS);
      send_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, FORCE_PRESS);
      send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORCE_NONE);

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         if (ph == 0)
            load_timing(1'b1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1, 16'd0, 1'b0);
         else if (ph == 1)
            load_timing(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 1'b1);
         else
            load_timing(coin(50), 16'($urandom_range(1, 6)), 16'($urandom_range(0, 6)),
                        16'($urandom_range(1, 8)), 16'($urandom_range(1, 25)),
                        16'($urandom_range(1, 25)), 16'($urandom), coin(50));
         @(posedge clock);
         if (ph == PHASES - 1)
            idle_pct = 0;
         else
            case ($urandom_range(0, 2))
               0:       idle_pct = 0;
               1:       idle_pct = 15;
               default: idle_pct = 30;
            endcase
         target = ticks_sent + ((ph == 1) ? 60 : 170);
         while (ticks_sent < target) run_episode();
      end

      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (5) @(posedge clock);
      $display("checked %0d ticks through start-up, directed and %0d random phases",
               ticks_checked, PHASES);
      $display("%0d shutdown requests seen, %0d of 12 machine codes reached",
               shutdowns_seen, $countones(codes_seen));
      if (failures == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
